/* hdl/segment_loglik_cost_defines.svh */
// Assertion helpers used by the checker file.
`ifndef SEGMENT_LOGLIK_COST_DEFINES_SVH
`define SEGMENT_LOGLIK_COST_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SLC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment cost check failed");

// Next-cycle implication, off while reset is high.
`define SLC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment cost check failed");

// Next-cycle implication, checked during reset too.
`define SLC_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("segment cost check failed");

`endif

/* hdl/slc_pkg.sv */
package slc_pkg;
   // base-2 log format and fixed-point alignment points
   localparam int LOG_FRAC  = 58;
   localparam int MANT_FRAC = 62;
   localparam int EXP_BITS  = 6;
   localparam int T_FRAC    = 32;
   localparam int ACC_FRAC  = 68;
   // ln 2 with 36 fraction bits
   localparam int LN2_BITS  = 36;
   localparam logic [LN2_BITS-1:0] LN2_Q = 36'hB17217F7D;
   // scaled sum is carried in this many bits before the ln 2 product
   localparam int TX_BITS   = 96;
   localparam int ACC_BITS  = 134;
   // log unit depth: find msb, normalize, two stages per squaring
   localparam int LOG_LAT   = 2 + 2 * LOG_FRAC;
endpackage

/* hdl/slc_log2.sv */
module slc_log2 import slc_pkg::*; #(
   parameter int CB = 40
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [CB-1:0] x_in,
   output logic [CB-1:0] x_out,
   output logic [63:0]   lg_out
);
   logic [CB-1:0]       x_ff [0:LOG_LAT-1];
   logic [EXP_BITS-1:0] e_ff [0:LOG_LAT-1];
   logic [63:0]         m_ff [0:LOG_FRAC];
   logic [LOG_FRAC-1:0] frac_ff [0:LOG_FRAC];
   logic [EXP_BITS-1:0] e_in;

   // msb position of the input
   always_comb begin
      e_in = '0;
      for (int i = 0; i < CB; i++) begin
         if (x_in[i]) e_in = EXP_BITS'(i);
      end
   end

   // exponent and count travel beside the mantissa
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= x_in;
         e_ff[0] <= e_in;
         for (int i = 1; i < LOG_LAT; i++) begin
            x_ff[i] <= x_ff[i-1];
            e_ff[i] <= e_ff[i-1];
         end
      end
   end

   // normalize to [1,2) with 62 fraction bits
   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0]    <= 64'(x_ff[0]) << (EXP_BITS'(MANT_FRAC) - e_ff[0]);
         frac_ff[0] <= '0;
      end
   end

   // one result bit per squaring, each squaring split over two stages
   for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
      logic [63:0]         pl_ff, pm_ff, ph_ff;
      logic [LOG_FRAC-1:0] fa_ff;
      logic [127:0]        sq;
      logic [63:0]         nm;

      always_ff @(posedge clock) begin
         if (adv) begin
            pl_ff <= m_ff[g][31:0] * m_ff[g][31:0];
            pm_ff <= m_ff[g][31:0] * m_ff[g][63:32];
            ph_ff <= m_ff[g][63:32] * m_ff[g][63:32];
            fa_ff <= frac_ff[g];
         end
      end

      always_comb begin
         sq = {ph_ff, 64'd0} + {31'd0, pm_ff, 33'd0} + {64'd0, pl_ff};
         nm = sq[125:62];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (nm[63]) begin
               m_ff[g+1]    <= nm >> 1;
               frac_ff[g+1] <= {fa_ff[LOG_FRAC-2:0], 1'b1};
            end else begin
               m_ff[g+1]    <= nm;
               frac_ff[g+1] <= {fa_ff[LOG_FRAC-2:0], 1'b0};
            end
         end
      end
   end

   assign x_out  = x_ff[LOG_LAT-1];
   assign lg_out = {e_ff[LOG_LAT-1], frac_ff[LOG_FRAC]};
endmodule

/* hdl/slc_xmul.sv */
module slc_xmul #(
   parameter int CB = 40
) (
   input  logic            clock,
   input  logic            adv,
   input  logic [CB-1:0]   x_in,
   input  logic [63:0]     lg_in,
   output logic [CB+63:0]  p_out
);
   logic [CB+31:0] plo_ff, phi_ff;
   logic [CB+63:0] p_ff;

   // two partial products, then the combine
   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff <= x_in * lg_in[31:0];
         phi_ff <= x_in * lg_in[63:32];
         p_ff   <= {phi_ff, 32'd0} + (CB+64)'(plo_ff);
      end
   end

   assign p_out = p_ff;
endmodule

/* hdl/slc_final.sv */
module slc_final import slc_pkg::*; #(
   parameter int CB = 40,
   parameter int FB = 16
) (
   input  logic                clock,
   input  logic                adv,
   input  logic signed [CB+66:0] t_in,
   input  logic [CB-1:0]       nst_in,
   input  logic                len_zero_in,
   output logic [63:0]         cost_out,
   output logic                sat_out
);
   localparam int SHT = LOG_FRAC - T_FRAC;
   localparam int S   = ACC_FRAC - FB;

   logic signed [TX_BITS-1:0]    tx;
   logic [LN2_BITS+31:0]         p0_ff, p1_ff;
   logic signed [LN2_BITS+32:0]  p2_ff;
   logic [CB-1:0]                nst1_ff;
   logic                         lz1_ff, lz2_ff;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in, q;
   logic [63:0]                  cost_ff;
   logic                         sat_ff;

   // floor to 32 fraction bits
   assign tx = TX_BITS'(t_in >>> SHT);

   // partial products with ln 2
   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff   <= tx[31:0] * LN2_Q;
         p1_ff   <= tx[63:32] * LN2_Q;
         p2_ff   <= $signed(tx[95:64]) * $signed({1'b0, LN2_Q});
         nst1_ff <= nst_in;
         lz1_ff  <= len_zero_in;
      end
   end

   // combine, add N and the rounding half
   always_comb begin
      acc_in = (ACC_BITS'(p2_ff) <<< 64)
             + $signed(ACC_BITS'({p1_ff, 32'd0}))
             + $signed(ACC_BITS'(p0_ff))
             + $signed(ACC_BITS'({nst1_ff, 68'd0}))
             + $signed(ACC_BITS'(1) << (S - 1));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff <= acc_in;
         lz2_ff <= lz1_ff;
      end
   end

   // scale to output format and clip
   assign q = acc_ff >>> S;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (lz2_ff) begin
            cost_ff <= '0;
            sat_ff  <= 1'b0;
         end else if ((&q[ACC_BITS-1:63]) || !(|q[ACC_BITS-1:63])) begin
            cost_ff <= q[63:0];
            sat_ff  <= 1'b0;
         end else begin
            cost_ff <= q[ACC_BITS-1] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
            sat_ff  <= 1'b1;
         end
      end
   end

   assign cost_out = cost_ff;
   assign sat_out  = sat_ff;
endmodule

/* hdl/segment_loglik_cost.sv */
// The pipeline depth is set by the 58 squarings of the log units, at two stages each.
// Throughput: one item per cycle; the whole pipeline holds while a result is
// stalled at the output register.
// Reset clears the valid bits only; data registers are not reset.
module segment_loglik_cost import slc_pkg::*; #(
   parameter int COUNT_BITS    = 40,
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COUNT_BITS-1:0] req_segment_length,
   input  logic [COUNT_BITS-1:0] req_read_starts,
   input  logic [COUNT_BITS-1:0] req_snp_count,
   input  logic [COUNT_BITS-1:0] req_total_bases,
   input  logic [COUNT_BITS-1:0] req_error_count,
   input  logic [COUNT_BITS-1:0] req_indel_count,
   input  logic [COUNT_BITS-1:0] req_zero_quality_reads,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_segment_cost,
   output logic                  rsp_saturated
);
   localparam int CB    = COUNT_BITS;
   localparam int PW    = CB + 64;
   localparam int TW    = PW + 3;
   localparam int NLOG  = 11;
   localparam int NPROD = 12;
   localparam int SW    = CB + 5;
   localparam int SD    = LOG_LAT + 3;
   localparam int LAT   = LOG_LAT + 8;

   logic                 adv;
   logic                 v_ff [0:LAT-1];
   logic [CB-1:0]        cnt_in [0:NLOG-1];
   logic [CB-1:0]        cnt_ff [0:NLOG-1];
   logic [CB-1:0]        xo [0:NLOG-1];
   logic [63:0]          lg [0:NLOG-1];
   logic [PW-1:0]        pr [0:NPROD-1];
   logic [SW-1:0]        side_in;
   logic [SW-1:0]        side_ff [0:SD-1];
   logic [3:0]           ok;
   logic signed [TW-1:0] term_ff [0:4];
   logic signed [TW-1:0] sum_ff;
   logic [CB-1:0]        tnst_ff, snst_ff;
   logic                 tlz_ff, slz_ff;

   // the whole pipeline moves unless the output item is held
   assign adv       = !(v_ff[LAT-1] && rsp_stall);
   assign req_stall = !adv;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   // counts and complements that need a log
   always_comb begin
      cnt_in[0]  = req_segment_length;
      cnt_in[1]  = req_read_starts;
      cnt_in[2]  = req_snp_count;
      cnt_in[3]  = req_segment_length - req_snp_count;
      cnt_in[4]  = req_total_bases;
      cnt_in[5]  = req_error_count;
      cnt_in[6]  = req_total_bases - req_error_count;
      cnt_in[7]  = req_indel_count;
      cnt_in[8]  = req_total_bases - req_indel_count;
      cnt_in[9]  = req_zero_quality_reads;
      cnt_in[10] = req_read_starts - req_zero_quality_reads;
      side_in = {
         (req_zero_quality_reads != '0) && (req_zero_quality_reads < req_read_starts),
         (req_indel_count != '0) && (req_indel_count < req_total_bases),
         (req_error_count != '0) && (req_error_count < req_total_bases),
         (req_snp_count != '0) && (req_snp_count < req_segment_length),
         req_segment_length == '0,
         req_read_starts};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NLOG; i++) cnt_ff[i] <= cnt_in[i];
         side_ff[0] <= side_in;
         for (int i = 1; i < SD; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // log units
   for (genvar g = 0; g < NLOG; g++) begin : g_log
      slc_log2 #(.CB(CB)) u_log (
         .clock (clock),
         .adv   (adv),
         .x_in  (cnt_ff[g]),
         .x_out (xo[g]),
         .lg_out(lg[g])
      );
   end

   // x lg y products: N lg L, N lg N, then each count times its own log
   for (genvar g = 0; g < NPROD; g++) begin : g_mul
      localparam int XI = (g < 2) ? 1 : ((g == 2) ? 0 : g - 1);
      localparam int LI = (g == 0) ? 0 : ((g == 1) ? 1 : ((g == 2) ? 0 : g - 1));
      slc_xmul #(.CB(CB)) u_mul (
         .clock(clock),
         .adv  (adv),
         .x_in (xo[XI]),
         .lg_in(lg[LI]),
         .p_out(pr[g])
      );
   end

   assign ok = side_ff[SD-1][SW-1:CB+1];

   // starts term and the four binomial terms
   always_ff @(posedge clock) begin
      if (adv) begin
         term_ff[0] <= $signed(TW'(pr[0])) - $signed(TW'(pr[1]));
         term_ff[1] <= ok[0] ? $signed(TW'(pr[2])) - $signed(TW'(pr[3]))
                               - $signed(TW'(pr[4])) : '0;
         term_ff[2] <= ok[1] ? $signed(TW'(pr[5])) - $signed(TW'(pr[6]))
                               - $signed(TW'(pr[7])) : '0;
         term_ff[3] <= ok[2] ? $signed(TW'(pr[5])) - $signed(TW'(pr[8]))
                               - $signed(TW'(pr[9])) : '0;
         term_ff[4] <= ok[3] ? $signed(TW'(pr[1])) - $signed(TW'(pr[10]))
                               - $signed(TW'(pr[11])) : '0;
         tnst_ff    <= side_ff[SD-1][CB-1:0];
         tlz_ff     <= side_ff[SD-1][CB];
      end
   end

   // total in log2 units
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff  <= term_ff[0] + term_ff[1] + term_ff[2] + term_ff[3] + term_ff[4];
         snst_ff <= tnst_ff;
         slz_ff  <= tlz_ff;
      end
   end

   slc_final #(.CB(CB), .FB(FRACTION_BITS)) u_final (
      .clock      (clock),
      .adv        (adv),
      .t_in       (sum_ff),
      .nst_in     (snst_ff),
      .len_zero_in(slz_ff),
      .cost_out   (rsp_segment_cost),
      .sat_out    (rsp_saturated)
   );

   assign rsp_valid = v_ff[LAT-1];
endmodule

/* hdl/slc_checker.sv */
`include "segment_loglik_cost_defines.svh"

module slc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_segment_cost,
   input logic        rsp_saturated
);
   logic out_held;
   logic cost_at_end;

   // output item offered but held by the receiver
   assign out_held    = rsp_valid && rsp_stall;
   // cost at either end of the signed range
   assign cost_at_end = (rsp_segment_cost == 64'h7FFFFFFFFFFFFFFF)
                     || (rsp_segment_cost == 64'h8000000000000000);

   // no item leaves right after reset
   `SLC_ASSERT_NXT_ALL(a_reset_empty, clock, reset, !rsp_valid)
   // a held item keeps its cost
   `SLC_ASSERT_NXT(a_hold, clock, reset, out_held, rsp_valid && $stable(rsp_segment_cost))
   // a clipped cost sits at one end of the range
   `SLC_ASSERT_IMP(a_sat_end, clock, reset, rsp_valid && rsp_saturated, cost_at_end)
   // input stalls only behind a held output item
   `SLC_ASSERT_IMP(a_stall_src, clock, reset, req_stall, out_held)
endmodule

bind segment_loglik_cost slc_checker u_slc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_segment_cost(rsp_segment_cost),
   .rsp_saturated   (rsp_saturated)
);
